>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FDMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FDMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/fdmd_pkg.sv
// ----------------------------------------------------------------------------
// fdmd_pkg
// Types and constants shared by the frame difference motion detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

  // frame store depth default
  localparam int unsigned MAX_FRAME_PIXELS_DEF = 262144;

  // field widths
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned FRAME_PIX_W = 19;
  localparam int unsigned THRESH_W    = 8;
  localparam int unsigned SHARE_W     = 14;
  localparam int unsigned COUNT_W     = 19;
  localparam int unsigned CFG_DATA_W  = 19;
  localparam int unsigned CFG_IDX_W   = 2;

  // gray conversion: (4899R + 9617G + 1868B + 8192) >> 14
  localparam int unsigned GRAY_R     = 4899;
  localparam int unsigned GRAY_G     = 9617;
  localparam int unsigned GRAY_B     = 1868;
  localparam int unsigned GRAY_ROUND = 8192;
  localparam int unsigned GRAY_SHIFT = 14;
  localparam int unsigned SUM_W      = 22;

  // limit comparison: count > floor(P/10000) holds exactly when count*10000 > P
  localparam int unsigned SHARE_SCALE = 10000;
  localparam int unsigned PROD_W      = FRAME_PIX_W + SHARE_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // decoupling queue
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIFF_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANGED_SHARE = 2'd2;

  // reset values
  localparam logic [FRAME_PIX_W-1:0] FRAME_PIXELS_RST = 19'd76800;
  localparam logic [THRESH_W-1:0]    DIFF_THRESH_RST  = 8'd25;
  localparam logic [SHARE_W-1:0]     CHANGED_SHARE_RST = 14'd100;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               inside_region;
    logic               end_of_frame;
  } pixel_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] changed_count;
    logic               motion_detected;
  } result_t;

  // classified pixel as it travels through the queue
  typedef struct packed {
    logic [LEVEL_W-1:0] gray;
    logic               inside_region;
    logic               end_of_frame;
    logic               primed;
  } pix_info_t;

  typedef struct packed {
    logic [FRAME_PIX_W-1:0] frame_pixels;
    logic [THRESH_W-1:0]    difference_threshold;
    logic [SHARE_W-1:0]     changed_share;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> src/fdmd_front.sv
// ----------------------------------------------------------------------------
// fdmd_front
// Accepts pixels, tags each with its store address and primed flag and
// converts it to gray before pushing it into the queue.
// ----------------------------------------------------------------------------
module fdmd_front #(
  parameter int unsigned MAX_FRAME_PIXELS = fdmd_pkg::MAX_FRAME_PIXELS_DEF,
  localparam int unsigned AddrW = $clog2(MAX_FRAME_PIXELS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fdmd_pkg::pixel_in_t in_pixel_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic [AddrW-1:0]    q_addr_o,
  output fdmd_pkg::pix_info_t q_info_o
);
  import fdmd_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_FRAME_PIXELS - 1);

  logic             accept;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             primed_q;
  logic             s1_v_q;
  logic [SUM_W-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_region_q, s1_last_q, s1_primed_q;
  logic [SUM_W-1:0] gray_sum;

  // stage advances whenever the queue has room
  assign q_push_o   = s1_v_q && !q_full_i;
  assign in_ready_o = !s1_v_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // raster position, wraps at the store depth and restarts after end of frame
  always_comb begin
    if (in_pixel_i.end_of_frame || pos_q == LastAddr) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      primed_q <= 1'b0;
      s1_v_q   <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
        if (in_pixel_i.end_of_frame) begin
          primed_q <= 1'b1;
        end
      end
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
    end
  end

  // weighted channel products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_r_q    <= SUM_W'(in_pixel_i.red_level) * SUM_W'(GRAY_R);
      prod_g_q    <= SUM_W'(in_pixel_i.green_level) * SUM_W'(GRAY_G);
      prod_b_q    <= SUM_W'(in_pixel_i.blue_level) * SUM_W'(GRAY_B);
      s1_addr_q   <= pos_q;
      s1_region_q <= in_pixel_i.inside_region;
      s1_last_q   <= in_pixel_i.end_of_frame;
      s1_primed_q <= primed_q;
    end
  end

  // rounded sum, top bits give the gray level
  assign gray_sum = prod_r_q + prod_g_q + prod_b_q + SUM_W'(GRAY_ROUND);

  assign q_addr_o               = s1_addr_q;
  assign q_info_o.gray          = gray_sum[GRAY_SHIFT +: LEVEL_W];
  assign q_info_o.inside_region = s1_region_q;
  assign q_info_o.end_of_frame  = s1_last_q;
  assign q_info_o.primed        = s1_primed_q;

endmodule

>>> src/fdmd_queue.sv
// ----------------------------------------------------------------------------
// fdmd_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module fdmd_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_W-1:0]     data_i,
  input  logic                  pop_i,
  output logic [DATA_W-1:0]     data_o,
  output fdmd_pkg::q_status_t   status_o
);
  import fdmd_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign status_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign data_o         = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/fdmd_back.sv
// ----------------------------------------------------------------------------
// fdmd_back
// Frame store access, change counting and end-of-frame motion decision.
// ----------------------------------------------------------------------------
module fdmd_back #(
  parameter int unsigned MAX_FRAME_PIXELS = fdmd_pkg::MAX_FRAME_PIXELS_DEF,
  localparam int unsigned AddrW = $clog2(MAX_FRAME_PIXELS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdmd_pkg::cfg_t      cfg_i,
  input  fdmd_pkg::q_status_t q_status_i,
  input  logic [AddrW-1:0]    q_addr_i,
  input  fdmd_pkg::pix_info_t q_info_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fdmd_pkg::result_t   out_result_o
);
  import fdmd_pkg::*;

  logic [LEVEL_W-1:0] frame_mem [MAX_FRAME_PIXELS];

  logic               en;
  logic               b1_v_q;
  pix_info_t          b1_info_q;
  logic [LEVEL_W-1:0] old_q;
  logic [LEVEL_W-1:0] diff;
  logic               changed;
  logic [COUNT_W-1:0] run_cnt_q, cnt_new;
  logic               b3_v_q;
  logic [COUNT_W-1:0] b3_cnt_q;
  logic               b4_v_q;
  logic [COUNT_W-1:0] b4_cnt_q;
  logic [PROD_W-1:0]  b4_prod_q;
  logic [PROD_W-1:0]  limit_q;
  logic               out_v_q;
  result_t            out_q;

  // whole pipeline holds only when a result meets a full output register
  assign en      = !(b4_v_q && out_v_q && !out_ready_i);
  assign q_pop_o = en && !q_status_i.empty;

  // scaled limit, refreshed every cycle from the registers
  always_ff @(posedge clk_i) begin
    limit_q <= PROD_W'(cfg_i.frame_pixels) * PROD_W'(cfg_i.changed_share);
  end

  // frame store: read-first, old value out and new gray in on one access
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      old_q              <= frame_mem[q_addr_i];
      frame_mem[q_addr_i] <= q_info_i.gray;
      b1_info_q          <= q_info_i;
    end
  end

  // change test and saturating count
  always_comb begin
    if (b1_info_q.gray > old_q) begin
      diff = b1_info_q.gray - old_q;
    end else begin
      diff = old_q - b1_info_q.gray;
    end
    changed = b1_info_q.primed && b1_info_q.inside_region &&
              (diff > cfg_i.difference_threshold) && (run_cnt_q != COUNT_MAX);
    cnt_new = run_cnt_q + COUNT_W'(changed);
  end

  // control of the back stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q    <= 1'b0;
      run_cnt_q <= '0;
      b3_v_q    <= 1'b0;
      b4_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      // output register: loaded from the last stage, held until taken
      out_v_q <= (en && b4_v_q) || (out_v_q && !out_ready_i);
      if (en) begin
        b1_v_q <= !q_status_i.empty;
        b3_v_q <= b1_v_q && b1_info_q.end_of_frame && b1_info_q.primed;
        b4_v_q <= b3_v_q;
        if (b1_v_q) begin
          run_cnt_q <= b1_info_q.end_of_frame ? '0 : cnt_new;
        end
      end
    end
  end

  // result payload: final count, scaled count, decision
  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_cnt_q  <= cnt_new;
      b4_cnt_q  <= b3_cnt_q;
      b4_prod_q <= PROD_W'(b3_cnt_q) * PROD_W'(SHARE_SCALE);
      if (b4_v_q) begin
        out_q.changed_count   <= b4_cnt_q;
        out_q.motion_detected <= (b4_prod_q > limit_q);
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_result_o = out_q;

endmodule

>>> src/frame_difference_motion_detector.sv
// ----------------------------------------------------------------------------
// frame_difference_motion_detector
// Gray-level frame differencing with a region mask and motion flag.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock in raster order; the figure is set by the
// single-port read-first frame store, which every pixel visits once to fetch
// its old gray value and write its new one. A frame's result (changed count
// and motion flag) follows its end-of-frame pixel through the front, queue,
// b1, b3, b4 and output registers. The first frame after reset only fills the
// store and yields no result. The store is not cleared at reset; a frame
// longer than every frame before it reads stale data. A waiting result does
// not stop pixel intake until the four-entry queue fills. The user must write
// registers via a plain write port only while the block is idle; unenforced.
`include "assert_macros.svh"

module frame_difference_motion_detector #(
  parameter int unsigned MAX_FRAME_PIXELS = fdmd_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fdmd_pkg::pixel_in_t                 in_pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fdmd_pkg::result_t                   out_result_o,
  input  logic                                cfg_we_i,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import fdmd_pkg::*;

  localparam int unsigned AddrW  = $clog2(MAX_FRAME_PIXELS);
  localparam int unsigned QDataW = AddrW + $bits(pix_info_t);

  cfg_t             cfg_q;
  logic             q_push, q_pop;
  q_status_t        q_status;
  logic [AddrW-1:0] push_addr, pop_addr;
  pix_info_t        push_info, pop_info;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_pixels         <= FRAME_PIXELS_RST;
      cfg_q.difference_threshold <= DIFF_THRESH_RST;
      cfg_q.changed_share        <= CHANGED_SHARE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_FRAME_PIXELS:  cfg_q.frame_pixels         <= cfg_data_i[FRAME_PIX_W-1:0];
        CFG_IDX_DIFF_THRESH:   cfg_q.difference_threshold <= cfg_data_i[THRESH_W-1:0];
        CFG_IDX_CHANGED_SHARE: cfg_q.changed_share        <= cfg_data_i[SHARE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: intake and classification
  fdmd_front #(
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_pixel_i(in_pixel_i),
    .q_full_i  (q_status.full),
    .q_push_o  (q_push),
    .q_addr_o  (push_addr),
    .q_info_o  (push_info)
  );

  // decoupling queue
  fdmd_queue #(
    .DATA_W(QDataW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({push_addr, push_info}),
    .pop_i   (q_pop),
    .data_o  ({pop_addr, pop_info}),
    .status_o(q_status)
  );

  // back: store access, counting and decision
  fdmd_back #(
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .q_addr_i    (pop_addr),
    .q_info_i    (pop_info),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_result_o(out_result_o)
  );

  // queue is never pushed when full nor popped when empty
  `FDMD_ASSERT_NOW(a_push_room, q_push, !q_status.full)
  `FDMD_ASSERT_NOW(a_pop_data, q_pop, !q_status.empty)
  // a full queue with no pop stays full
  `FDMD_ASSERT_NEXT(a_full_stall, q_status.full && !q_pop, q_status.full)

endmodule
